>>> rtl/dwe_pkg.sv
`default_nettype none
package dwe_pkg;

	// Shared pipeline control: global advance and the valid bit entering a unit
	typedef struct packed {
		logic en;
		logic vld;
	} stage_ctl_t;

endpackage
`default_nettype wire

>>> rtl/divide_with_error_propagation.sv
`default_nettype none
// Pipelined; the depth is set mostly by the one-bit-per-stage quotient divider,
// square root and error divider, which sit in series.
// Throughput: one request per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
module divide_with_error_propagation #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] left_value,
	input  logic        [DATA_WIDTH-2:0] left_error,
	input  logic signed [DATA_WIDTH-1:0] right_value,
	input  logic        [DATA_WIDTH-2:0] right_error,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic signed [DATA_WIDTH-1:0] quotient_error,
	output logic                         divide_by_zero,
	output logic                         overflow
);
	import dwe_pkg::*;

	localparam int W   = DATA_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int QW  = W + F;
	localparam int NW  = 4 * W;
	localparam int RW  = 2 * W;
	localparam int XW  = 2 * W + F;
	localparam int CW  = 3 * W + F + 1;
	localparam int SW1 = 2 * (W - 1) + 2 * W + 3;
	localparam int SW2 = 3 * W + 4;
	localparam int SW3 = W + 5;

	localparam logic [W-1:0] PMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NMAX = {1'b1, {(W-1){1'b0}}};

	logic en;

	// stage 1: magnitudes
	logic [W-1:0] lv_u, rv_u, am_c, bm_c;
	logic         vld_s1;
	logic [W-1:0] am_s1, bm_s1;
	logic [W-2:0] sa_s1, sb_s1;
	logic         an_s1, bn_s1, bz_s1;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign lv_u     = $unsigned(left_value);
	assign rv_u     = $unsigned(right_value);
	assign am_c     = lv_u[W-1] ? ({W{1'b0}} - lv_u) : lv_u;
	assign bm_c     = rv_u[W-1] ? ({W{1'b0}} - rv_u) : rv_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1 <= am_c;
			bm_s1 <= bm_c;
			sa_s1 <= left_error;
			sb_s1 <= right_error;
			an_s1 <= lv_u[W-1];
			bn_s1 <= rv_u[W-1];
			bz_s1 <= (bm_c == '0);
		end
	end

	// quotient divider
	stage_ctl_t    ctl_q;
	logic [QW-1:0] qbits;
	logic [QW-1:0] qraw;
	logic          vld_q;
	logic [SW1-1:0] side_q;
	logic [W-2:0]  sa_q, sb_q;
	logic [W-1:0]  am_q, bm_q;
	logic          an_q, bn_q, bz_q;

	assign ctl_q = '{en: en, vld: vld_s1};
	assign qbits = QW'(am_s1) << F;

	dwe_div #(.DW(W), .QW(QW), .SW(SW1)) u_qdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_q),
		.rem_in  ({W{1'b0}}),
		.bits_in (qbits),
		.dvsr    (bm_s1),
		.side_in ({sa_s1, sb_s1, am_s1, bm_s1, an_s1, bn_s1, bz_s1}),
		.vld_out (vld_q),
		.quo     (qraw),
		.side_out(side_q)
	);

	assign {sa_q, sb_q, am_q, bm_q, an_q, bn_q, bz_q} = side_q;

	// stage 2: quotient saturation, cross products
	logic         qneg, qsat_c;
	logic [W-1:0] qlim, qmag;
	logic [2*W-2:0] p_c, q_c;
	logic         vld_s2;
	logic [W-1:0] qv_s2, bm_s2;
	logic         qsat_s2, an_s2, bn_s2, bz_s2;
	logic [2*W-2:0] p_s2, q_s2;

	assign qneg   = an_q ^ bn_q;
	assign qlim   = qneg ? NMAX : PMAX;
	assign qsat_c = qraw > QW'(qlim);
	assign qmag   = qsat_c ? qlim : qraw[W-1:0];
	assign p_c    = sa_q * bm_q;
	assign q_c    = am_q * sb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qv_s2   <= qneg ? ({W{1'b0}} - qmag) : qmag;
			qsat_s2 <= qsat_c;
			p_s2    <= p_c;
			q_s2    <= q_c;
			bm_s2   <= bm_q;
			an_s2   <= an_q;
			bn_s2   <= bn_q;
			bz_s2   <= bz_q;
		end
	end

	// stage 3: partial products of the squares, divisor squared
	logic           vld_s3;
	logic [2*W-1:0] pll_s3, qll_s3, d_s3;
	logic [2*W-2:0] plh_s3, qlh_s3;
	logic [2*W-3:0] phh_s3, qhh_s3;
	logic [W-1:0]   qv_s3;
	logic           qsat_s3, an_s3, bn_s3, bz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s3  <= p_s2[W-1:0] * p_s2[W-1:0];
			plh_s3  <= p_s2[W-1:0] * p_s2[2*W-2:W];
			phh_s3  <= p_s2[2*W-2:W] * p_s2[2*W-2:W];
			qll_s3  <= q_s2[W-1:0] * q_s2[W-1:0];
			qlh_s3  <= q_s2[W-1:0] * q_s2[2*W-2:W];
			qhh_s3  <= q_s2[2*W-2:W] * q_s2[2*W-2:W];
			d_s3    <= bm_s2 * bm_s2;
			qv_s3   <= qv_s2;
			qsat_s3 <= qsat_s2;
			an_s3   <= an_s2;
			bn_s3   <= bn_s2;
			bz_s3   <= bz_s2;
		end
	end

	// stage 4: squares; stage 5: sum of squares
	logic           vld_s4, vld_s5;
	logic [NW-1:0]  psq_s4, qsq_s4, n_s5;
	logic [2*W-1:0] d_s4, d_s5;
	logic [W-1:0]   qv_s4, qv_s5;
	logic           qsat_s4, an_s4, bn_s4, bz_s4;
	logic           qsat_s5, an_s5, bn_s5, bz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psq_s4  <= (NW'(phh_s3) << (2 * W)) + (NW'(plh_s3) << (W + 1)) + NW'(pll_s3);
			qsq_s4  <= (NW'(qhh_s3) << (2 * W)) + (NW'(qlh_s3) << (W + 1)) + NW'(qll_s3);
			d_s4    <= d_s3;
			qv_s4   <= qv_s3;
			qsat_s4 <= qsat_s3;
			an_s4   <= an_s3;
			bn_s4   <= bn_s3;
			bz_s4   <= bz_s3;
			n_s5    <= psq_s4 + qsq_s4;
			d_s5    <= d_s4;
			qv_s5   <= qv_s4;
			qsat_s5 <= qsat_s4;
			an_s5   <= an_s4;
			bn_s5   <= bn_s4;
			bz_s5   <= bz_s4;
		end
	end

	// square root
	stage_ctl_t     ctl_r;
	logic           vld_r;
	logic [RW-1:0]  root_r;
	logic [SW2-1:0] side_r;
	logic [2*W-1:0] d_r;
	logic [W-1:0]   qv_r;
	logic           qsat_r, bn_r, bz_r, an_r;

	assign ctl_r = '{en: en, vld: vld_s5};

	dwe_sqrt #(.RW(RW), .SW(SW2)) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_r),
		.radicand(n_s5),
		.side_in ({d_s5, qv_s5, qsat_s5, bn_s5, bz_s5, an_s5}),
		.vld_out (vld_r),
		.root    (root_r),
		.side_out(side_r)
	);

	assign {d_r, qv_r, qsat_r, bn_r, bz_r, an_r} = side_r;

	// stage 6: scale root, check error range against (limit + 1) * b^2
	logic [XW-1:0]  x_c, xh_c;
	logic [CW-1:0]  cmp_c;
	logic           vld_s6;
	logic [RW-1:0]  rem_s6, d_s6;
	logic [W-1:0]   bits_s6, qv_s6;
	logic           esat_s6, qsat_s6, bn_s6, bz_s6, an_s6;

	assign x_c   = XW'(root_r) << F;
	assign xh_c  = x_c >> W;
	assign cmp_c = (CW'(d_r) << (W - 1)) + (bn_r ? CW'(d_r) : {CW{1'b0}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			esat_s6 <= cmp_c <= CW'(x_c);
			rem_s6  <= xh_c[RW-1:0];
			bits_s6 <= x_c[W-1:0];
			d_s6    <= d_r;
			qv_s6   <= qv_r;
			qsat_s6 <= qsat_r;
			bn_s6   <= bn_r;
			bz_s6   <= bz_r;
			an_s6   <= an_r;
		end
	end

	// error divider
	stage_ctl_t     ctl_e;
	logic           vld_e;
	logic [W-1:0]   eq_e;
	logic [SW3-1:0] side_e;
	logic [W-1:0]   qv_e;
	logic           qsat_e, bn_e, bz_e, an_e, esat_e;

	assign ctl_e = '{en: en, vld: vld_s6};

	dwe_div #(.DW(RW), .QW(W), .SW(SW3)) u_ediv (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_e),
		.rem_in  (rem_s6),
		.bits_in (bits_s6),
		.dvsr    (d_s6),
		.side_in ({qv_s6, qsat_s6, bn_s6, bz_s6, an_s6, esat_s6}),
		.vld_out (vld_e),
		.quo     (eq_e),
		.side_out(side_e)
	);

	assign {qv_e, qsat_e, bn_e, bz_e, an_e, esat_e} = side_e;

	// stage 7: output register
	logic [W-1:0] emag;
	logic         vld_s7;
	logic [W-1:0] quo_s7, err_s7;
	logic         dz_s7, ovf_s7;

	assign emag = esat_e ? (bn_e ? NMAX : PMAX) : eq_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_e;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (bz_e) begin
				quo_s7 <= an_e ? NMAX : PMAX;
				err_s7 <= PMAX;
				dz_s7  <= 1'b1;
				ovf_s7 <= 1'b0;
			end else begin
				quo_s7 <= qv_e;
				err_s7 <= bn_e ? ({W{1'b0}} - emag) : emag;
				dz_s7  <= 1'b0;
				ovf_s7 <= qsat_e || esat_e;
			end
		end
	end

	assign out_valid      = vld_s7;
	assign quotient       = $signed(quo_s7);
	assign quotient_error = $signed(err_s7);
	assign divide_by_zero = dz_s7;
	assign overflow       = ovf_s7;

`ifndef SYNTHESIS
	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> !overflow)
		else $error("divide by zero flagged together with overflow");

	a_dz_err_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> quo_s7 != {W{1'b0}} && err_s7 == PMAX)
		else $error("divide by zero result not saturated");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> quo_s7 == PMAX || quo_s7 == NMAX ||
			err_s7 == PMAX || err_s7 == NMAX)
		else $error("overflow flagged without a saturated result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s6) && $stable(rem_s6))
		else $error("pipeline advanced during stall");
`endif

endmodule
`default_nettype wire

>>> rtl/dwe_div.sv
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage.
// Expects rem_in < dvsr; the low QW dividend bits are shifted in one per stage.
module dwe_div #(
	parameter int DW = 32,
	parameter int QW = 48,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dwe_pkg::stage_ctl_t  ctl,
	input  logic [DW-1:0]        rem_in,
	input  logic [QW-1:0]        bits_in,
	input  logic [DW-1:0]        dvsr,
	input  logic [SW-1:0]        side_in,
	output logic                 vld_out,
	output logic [QW-1:0]        quo,
	output logic [SW-1:0]        side_out
);
	import dwe_pkg::*;

	logic          vld_s  [QW];
	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] bits_s [QW];
	logic [DW-1:0] dv_s   [QW];
	logic [SW-1:0] side_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic          vp;
		logic [DW-1:0] rp;
		logic [QW-1:0] bp;
		logic [DW-1:0] dp;
		logic [SW-1:0] sp;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          take;

		if (g == 0) begin : g_first
			assign vp = ctl.vld;
			assign rp = rem_in;
			assign bp = bits_in;
			assign dp = dvsr;
			assign sp = side_in;
		end else begin : g_next
			assign vp = vld_s[g-1];
			assign rp = rem_s[g-1];
			assign bp = bits_s[g-1];
			assign dp = dv_s[g-1];
			assign sp = side_s[g-1];
		end

		assign trial = {rp, bp[QW-1]};
		assign take  = trial >= {1'b0, dp};
		assign diff  = trial - {1'b0, dp};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[g] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[g]  <= take ? diff[DW-1:0] : trial[DW-1:0];
				bits_s[g] <= {bp[QW-2:0], take};
				dv_s[g]   <= dp;
				side_s[g] <= sp;
			end
		end
	end

	assign vld_out  = vld_s[QW-1];
	assign quo      = bits_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule
`default_nettype wire

>>> rtl/dwe_sqrt.sv
`default_nettype none
// Digit-by-digit integer square root, one root bit per pipeline stage.
module dwe_sqrt #(
	parameter int RW = 64,
	parameter int SW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dwe_pkg::stage_ctl_t  ctl,
	input  logic [2*RW-1:0]      radicand,
	input  logic [SW-1:0]        side_in,
	output logic                 vld_out,
	output logic [RW-1:0]        root,
	output logic [SW-1:0]        side_out
);
	import dwe_pkg::*;

	logic            vld_s  [RW];
	logic [RW:0]     rem_s  [RW];
	logic [RW-1:0]   root_s [RW];
	logic [2*RW-1:0] n_s    [RW];
	logic [SW-1:0]   side_s [RW];

	for (genvar g = 0; g < RW; g++) begin : g_stage
		logic            vp;
		logic [RW:0]     rp;
		logic [RW-1:0]   tp;
		logic [2*RW-1:0] np;
		logic [SW-1:0]   sp;
		logic [RW+2:0]   rem2;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            take;

		if (g == 0) begin : g_first
			assign vp = ctl.vld;
			assign rp = '0;
			assign tp = '0;
			assign np = radicand;
			assign sp = side_in;
		end else begin : g_next
			assign vp = vld_s[g-1];
			assign rp = rem_s[g-1];
			assign tp = root_s[g-1];
			assign np = n_s[g-1];
			assign sp = side_s[g-1];
		end

		// bring down the next two radicand bits, try root bit one
		assign rem2  = {rp, np[2*RW-1 -: 2]};
		assign trial = {1'b0, tp, 2'b01};
		assign take  = rem2 >= trial;
		assign diff  = rem2 - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[g] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[g]  <= take ? diff[RW:0] : rem2[RW:0];
				root_s[g] <= {tp[RW-2:0], take};
				n_s[g]    <= {np[2*RW-3:0], 2'b00};
				side_s[g] <= sp;
			end
		end
	end

	assign vld_out  = vld_s[RW-1];
	assign root     = root_s[RW-1];
	assign side_out = side_s[RW-1];

endmodule
`default_nettype wire

>>> sim/divide_with_error_propagation_test.sv
module divide_with_error_propagation_test;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_MAX = {1'b1, {(DW-1){1'b0}}};

	typedef struct {
		logic [DW-1:0] quotient;
		logic [DW-1:0] quotient_error;
		logic          divide_by_zero;
		logic          overflow;
	} bin_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [DW-1:0] left_value;
	logic        [DW-2:0] left_error;
	logic signed [DW-1:0] right_value;
	logic        [DW-2:0] right_error;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [DW-1:0] quotient;
	logic signed [DW-1:0] quotient_error;
	logic                 divide_by_zero;
	logic                 overflow;

	bin_result_t expected_bins[$];
	int          error_count;
	int          stall_pct;
	bit          long_hold;

	divide_with_error_propagation #(
		.DATA_WIDTH(DW),
		.FRAC_BITS (FB)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_value    (left_value),
		.left_error    (left_error),
		.right_value   (right_value),
		.right_error   (right_error),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.quotient      (quotient),
		.quotient_error(quotient_error),
		.divide_by_zero(divide_by_zero),
		.overflow      (overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bin_result_t divide_bin(logic [DW-1:0] a, logic [DW-2:0] sa,
			logic [DW-1:0] b, logic [DW-2:0] sb);
		logic          an, bn, qneg;
		logic [DW-1:0] am, bm;
		logic [127:0]  qmag, qlim, elim, emag, t1, t2, n, r, c, x, d;
		logic          qsat, esat;
		bin_result_t   res;
		an = a[DW-1];
		bn = b[DW-1];
		am = an ? -a : a;
		bm = bn ? -b : b;
		if (bm == 0) begin
			res.quotient       = an ? NEG_MAX : POS_MAX;
			res.quotient_error = POS_MAX;
			res.divide_by_zero = 1'b1;
			res.overflow       = 1'b0;
			return res;
		end
		qneg = an != bn;
		qlim = qneg ? 128'(NEG_MAX) : 128'(POS_MAX);
		qmag = (128'(am) << FB) / 128'(bm);
		qsat = qmag > qlim;
		if (qsat)
			qmag = qlim;
		if (qmag == 0)
			qneg = 1'b0;
		// exact sum of squares, then integer square root
		t1 = 128'(sa) * 128'(bm);
		t2 = 128'(am) * 128'(sb);
		n  = t1 * t1 + t2 * t2;
		r  = 0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (128'(1) << i);
			if (c * c <= n)
				r = c;
		end
		x    = r << FB;
		d    = 128'(bm) * 128'(bm);
		elim = bn ? 128'(NEG_MAX) : 128'(POS_MAX);
		esat = (elim + 1) * d <= x;
		emag = esat ? elim : x / d;
		res.quotient       = qneg ? -qmag[DW-1:0] : qmag[DW-1:0];
		res.quotient_error = (bn && emag != 0) ? -emag[DW-1:0] : emag[DW-1:0];
		res.divide_by_zero = 1'b0;
		res.overflow       = qsat || esat;
		return res;
	endfunction

	// Offer one request and hold it until taken; valid stays high afterwards.
	task automatic send_bin(logic [DW-1:0] a, logic [DW-2:0] sa, logic [DW-1:0] b,
			logic [DW-2:0] sb);
		in_valid    <= 1'b1;
		left_value  <= a;
		left_error  <= sa;
		right_value <= b;
		right_error <= sb;
		do
			@(posedge clk);
		while (!in_ready);
		expected_bins.push_back(divide_bin(a, sa, b, sb));
	endtask

	task automatic idle_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return DW'($urandom_range(0, 3)) - 1;
			3: return DW'(int'($urandom_range(0, 2047)) - 1024);
			4: return DW'(int'($urandom_range(0, 20)) - 10) <<< FB;
			5: return 0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [DW-2:0] pick_error();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return 0;
			2: return (DW-1)'($urandom_range(0, 65536));
			3: return (DW-1)'($urandom_range(0, 255));
			default: return (DW-1)'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_bin(32'h0001_0000, 31'h0, 32'h0, 31'h0);
		send_bin(32'hffff_0000, 31'h1, 32'h0, 31'h5);
		send_bin(32'h0, 31'h0, 32'h0, 31'h0);
		send_bin(NEG_MAX, '1, 32'h0, '1);
		send_bin(NEG_MAX, 31'h0, 32'hffff_ffff, 31'h0);
		send_bin(NEG_MAX, 31'h0, 32'h0001_0000, 31'h0);
		send_bin(POS_MAX, 31'h0, 32'h1, 31'h0);
		send_bin(POS_MAX, '1, NEG_MAX, '1);
		send_bin(NEG_MAX, '1, NEG_MAX, '1);
		send_bin(POS_MAX, '1, POS_MAX, '1);
		send_bin(32'h0, 31'h0, 32'h0001_0000, 31'h0);
		send_bin(32'h0, 31'h0001_0000, 32'hffff_0000, 31'h0);
		send_bin(32'h0003_0000, 31'h0000_4000, 32'h0002_0000, 31'h0000_8000);
		send_bin(32'h0003_0000, 31'h0000_4000, 32'hfffe_0000, 31'h0000_8000);
		send_bin(32'hfffd_0000, 31'h0, 32'h0002_0000, 31'h0001_0000);
		send_bin(32'h1, '1, 32'h1, '1);
		send_bin(32'h1, 31'h0, POS_MAX, 31'h0);
		send_bin(32'hffff_ffff, 31'h1, 32'hffff_ffff, 31'h1);
		send_bin(32'h5555_5555, 31'h2aaa_aaaa, 32'haaaa_aaaa, 31'h5555_5555);
		send_bin(32'h0000_8000, 31'h0, 32'h0100_0000, 31'h0);
		idle_sender(1);
	endtask

	task automatic run_bursts(int count);
		int burst;
		burst = $urandom_range(1, 40);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_bin(pick_value(), pick_error(), 32'h0, pick_error());
			else
				send_bin(pick_value(), pick_error(), pick_value(), pick_error());
			burst--;
			if (burst == 0) begin
				if ($urandom_range(0, 2) != 0)
					idle_sender($urandom_range(1, 12));
				burst = $urandom_range(1, 40);
			end
		end
		idle_sender(1);
	endtask

	task automatic test_random();
		for (int phase = 0; phase < 6; phase++) begin
			stall_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 30 : 75;
			run_bursts(250);
		end
	endtask

	// Hold the receiver off while requests keep coming, so the pipeline backs up.
	task automatic test_backpressure();
		stall_pct = 0;
		long_hold = 1'b1;
		run_bursts(100);
		stall_pct = 20;
		run_bursts(60);
	endtask

	initial begin
		int hold;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(posedge clk);
				long_hold = 1'b0;
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		bin_result_t exp_bin;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bins.size() == 0) begin
				$display("%0t: unexpected result q=%h", $time, quotient);
				error_count++;
			end else begin
				exp_bin = expected_bins.pop_front();
				if (quotient !== exp_bin.quotient) begin
					$display("%0t: quotient expected %h actual %h", $time,
						exp_bin.quotient, quotient);
					error_count++;
				end
				if (quotient_error !== exp_bin.quotient_error) begin
					$display("%0t: quotient_error expected %h actual %h", $time,
						exp_bin.quotient_error, quotient_error);
					error_count++;
				end
				if (divide_by_zero !== exp_bin.divide_by_zero) begin
					$display("%0t: divide_by_zero expected %b actual %b", $time,
						exp_bin.divide_by_zero, divide_by_zero);
					error_count++;
				end
				if (overflow !== exp_bin.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time,
						exp_bin.overflow, overflow);
					error_count++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		error_count = 0;
		stall_pct   = 25;
		long_hold   = 1'b0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		left_value  = '0;
		left_error  = '0;
		right_value = '0;
		right_error = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		while (expected_bins.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
